[hw/rtl/hmc_pkg.sv]
package hmc_pkg;

    // Sizing
    localparam int MAX_LEAVES  = 1024;
    localparam int WEIGHT_BITS = 16;
    localparam int WEIGHT_PORT = 16;
    localparam int IDX_BITS    = $clog2(MAX_LEAVES);
    localparam int CNT_BITS    = $clog2(MAX_LEAVES + 1);
    localparam int KEY_BITS    = WEIGHT_BITS + IDX_BITS;
    localparam int COST_BITS   = 48;

    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(MAX_LEAVES);
    localparam logic [KEY_BITS-1:0] WEIGHT_MASK = (KEY_BITS'(1) << WEIGHT_BITS) - KEY_BITS'(1);

    typedef logic [KEY_BITS-1:0] key_t;

    // One neighbor slot as seen by a cell: stored key and whether it is occupied
    typedef struct packed {
        key_t val;
        logic occ;
    } slot_t;

    // Slots around cell i: i-1, i, i+1, i+2
    typedef struct packed {
        slot_t m1;
        slot_t c0;
        slot_t p1;
        slot_t p2;
    } nbr_t;

    // Broadcast control for the whole row
    typedef struct packed {
        logic en;     // update this cycle
        logic merge;  // drop the two front entries while inserting
        key_t key;    // key being inserted
    } cell_ctl_t;

endpackage

[hw/rtl/hmc_cell.sv]
// One slot of the sorted row. Smallest key lives in slot 0; empty slots act as +inf.
module hmc_cell (
    input  logic               clk,
    input  hmc_pkg::cell_ctl_t ctl,
    input  hmc_pkg::nbr_t      nbr,
    output hmc_pkg::key_t      val
);

    hmc_pkg::slot_t prev_slot;
    hmc_pkg::slot_t cur_slot;
    logic           gt_prev;
    logic           gt_cur;
    hmc_pkg::key_t  val_reg;
    hmc_pkg::key_t  val_next;

    // Plain insert looks at i-1 and i; merge looks at the row shifted by two
    always_comb
    begin
        prev_slot = ctl.merge ? nbr.p1 : nbr.m1;
        cur_slot  = ctl.merge ? nbr.p2 : nbr.c0;
    end

    // Sorted insert: take the left value if it moves right, else the key if it lands here, else the current value
    always_comb
    begin
        gt_prev = !prev_slot.occ || (prev_slot.val > ctl.key);
        gt_cur  = !cur_slot.occ || (cur_slot.val > ctl.key);
        if (gt_prev)
        begin
            val_next = prev_slot.val;
        end
        else if (gt_cur)
        begin
            val_next = ctl.key;
        end
        else
        begin
            val_next = cur_slot.val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

[hw/rtl/huffman_merge_cost_unit.sv]
// Huffman merge cost unit. Leaf weights are taken one request per cycle, while not stalled, into
// a sorted row of hmc_pkg::MAX_LEAVES cells (two compares per cell, smallest at the front); a leaf
// arriving while the row is full is dropped. The request with is_last set starts the merge phase,
// in which each merge has a sum step, adding the two front entries into the cost, and an insert
// step, dropping them and inserting their sum into the row in place. New requests stall during
// the merge phase, until the result is posted. The cost waits in an output register, so the next
// set may start loading before it is taken. A single leaf costs 0.
module huffman_merge_cost_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [hmc_pkg::WEIGHT_PORT-1:0]     weight,
    input  logic                                is_last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hmc_pkg::COST_BITS-1:0]       total_cost
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_INS
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [hmc_pkg::CNT_BITS-1:0]    count_reg;
    logic [hmc_pkg::CNT_BITS-1:0]    count_next;
    logic [hmc_pkg::COST_BITS-1:0]   cost_reg;
    logic [hmc_pkg::COST_BITS-1:0]   cost_next;
    hmc_pkg::key_t                   sum_reg;
    hmc_pkg::key_t                   sum_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [hmc_pkg::COST_BITS-1:0]   total_cost_reg;
    logic [hmc_pkg::COST_BITS-1:0]   total_cost_next;

    logic                            in_accept;
    logic                            out_free;
    hmc_pkg::cell_ctl_t              ctl;
    hmc_pkg::key_t                   cell_val [hmc_pkg::MAX_LEAVES];
    logic [hmc_pkg::MAX_LEAVES-1:0]  occ;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Row control: load inserts the leaf, merge drops the front pair and inserts the sum
    always_comb
    begin
        ctl.en    = (in_accept && (count_reg != hmc_pkg::CNT_FULL)) || (state_reg == ST_INS);
        ctl.merge = (state_reg == ST_INS);
        ctl.key   = (state_reg == ST_INS) ? sum_reg
                    : (hmc_pkg::KEY_BITS'(weight) & hmc_pkg::WEIGHT_MASK);
    end

    // Cell row
    for (genvar i = 0; i < hmc_pkg::MAX_LEAVES; i++)
    begin : g_cell
        localparam logic [hmc_pkg::CNT_BITS-1:0] POS = hmc_pkg::CNT_BITS'(i);
        hmc_pkg::nbr_t nbr;

        assign occ[i] = POS < count_reg;

        if (i == 0)
        begin : g_first
            assign nbr.m1 = '{val: '0, occ: 1'b1};
        end
        else
        begin : g_mid
            assign nbr.m1 = '{val: cell_val[i-1], occ: occ[i-1]};
        end

        assign nbr.c0 = '{val: cell_val[i], occ: occ[i]};

        if (i + 1 < hmc_pkg::MAX_LEAVES)
        begin : g_p1
            assign nbr.p1 = '{val: cell_val[i+1], occ: occ[i+1]};
        end
        else
        begin : g_p1_end
            assign nbr.p1 = '{val: '0, occ: 1'b0};
        end

        if (i + 2 < hmc_pkg::MAX_LEAVES)
        begin : g_p2
            assign nbr.p2 = '{val: cell_val[i+2], occ: occ[i+2]};
        end
        else
        begin : g_p2_end
            assign nbr.p2 = '{val: '0, occ: 1'b0};
        end

        hmc_cell u_cell (
            .clk (clk),
            .ctl (ctl),
            .nbr (nbr),
            .val (cell_val[i])
        );
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cost_next       = cost_reg;
        sum_next        = sum_reg;
        out_valid_next  = out_valid_reg && out_stall;
        total_cost_next = total_cost_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (count_reg != hmc_pkg::CNT_FULL)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (is_last)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                if (count_reg > hmc_pkg::CNT_BITS'(1))
                begin
                    sum_next   = cell_val[0] + cell_val[1];
                    cost_next  = cost_reg + hmc_pkg::COST_BITS'(sum_next);
                    state_next = ST_INS;
                end
                else if (out_free)
                begin
                    total_cost_next = cost_reg;
                    out_valid_next  = 1'b1;
                    count_next      = '0;
                    cost_next       = '0;
                    state_next      = ST_IDLE;
                end
            end
            ST_INS:
            begin
                // two out, one in
                count_next = count_reg - 1'b1;
                state_next = ST_SUM;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            cost_reg       <= '0;
            out_valid_reg  <= 1'b0;
            total_cost_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            cost_reg       <= cost_next;
            out_valid_reg  <= out_valid_next;
            total_cost_reg <= total_cost_next;
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign total_cost = total_cost_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hmc_pkg::CNT_FULL)
        else $error("entry count beyond row size");

    a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM && count_reg > hmc_pkg::CNT_BITS'(1)) |-> cell_val[0] <= cell_val[1])
        else $error("front of row out of order");

    a_ins_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS) |-> count_reg >= hmc_pkg::CNT_BITS'(2))
        else $error("merge insert with fewer than two entries");

    a_post_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (count_reg == '0 && cost_reg == '0 && state_reg == ST_IDLE))
        else $error("result posted without clearing the set");

endmodule
